FILE: hdl/fpms_pkg.sv
// shared types, constants and character helpers for the fuzzy path match scorer
package fpms_pkg;

   localparam int MAX_QUERY    = 32;
   localparam int MAX_PATH_LEN = 4096;

   localparam int QLEN_W  = $clog2(MAX_QUERY + 1);
   localparam int PATH_W  = $clog2(MAX_PATH_LEN + 1);
   localparam int SCORE_W = 10;
   localparam int SCORE_MAX = 1023;

   // points per matched character
   localparam int E_BASE_PTS = 2;
   localparam int E_ADJ_PTS  = 2;
   localparam int E_BND_PTS  = 3;
   localparam int C_BASE_PTS = 1;
   localparam int C_ADJ_PTS  = 1;
   localparam int C_BND_PTS  = 2;

   // end of path bonus terms
   localparam int E_CONT_MULT = 3;
   localparam int C_CONT_MULT = 2;
   localparam int E_LEN_DIV   = 10;
   localparam int C_LEN_DIV   = 20;

   localparam int PTS_W = $clog2((E_BASE_PTS + E_ADJ_PTS + E_BND_PTS) * MAX_QUERY + 1);

   localparam logic CMD_QUERY = 1'b0;
   localparam logic CMD_PATH  = 1'b1;

   typedef struct packed {
      logic       command;
      logic [7:0] char_byte;
      logic       last;
   } req_type;

   typedef struct packed {
      logic [SCORE_W-1:0] score;
      logic               case_exact;
      logic               truncated;
   } rsp_type;

   // broadcast controls from the top level to every cell
   typedef struct packed {
      logic qwr;
      logic new_query;
      logic step;
      logic clear;
   } cell_ctl_type;

   // what a cell hands to its right neighbor
   typedef struct packed {
      logic used;
      logic ehit;
      logic chit;
      logic ewin;
      logic cwin;
   } link_type;

   // per cell status gathered by the top level
   typedef struct packed {
      logic eact;
      logic ehit;
      logic cact;
      logic chit;
      logic econt;
      logic ccont;
   } cell_stat_type;

   // snapshot of a finished path
   typedef struct packed {
      logic              exact_ok;
      logic              caseless_ok;
      logic              contained;
      logic [PTS_W-1:0]  pts;
      logic [QLEN_W-1:0] qlen;
      logic [PATH_W-1:0] plen;
      logic              truncated;
   } fin_type;

   function automatic logic is_alnum(input logic [7:0] c);
      return (c inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]});
   endfunction

   function automatic logic [7:0] lower_ascii(input logic [7:0] c);
      return (c inside {[8'h41:8'h5A]}) ? c + 8'd32 : c;
   endfunction

endpackage

FILE: hdl/fpms_cell.sv
// one query position: stored character, match tokens and shift-and window bits
module fpms_cell import fpms_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  cell_ctl_type  ctl,
   input  logic [7:0]    char_byte,
   input  logic [7:0]    char_lower,
   input  logic          head,
   input  link_type      prev,
   input  logic          next_used,
   output link_type      link,
   output cell_stat_type stat
);

   logic [7:0] qchar_ff;
   logic       used_ff, used_in;
   logic       etok_ff, etok_in;
   logic       ctok_ff, ctok_in;
   logic       ewin_ff, ewin_in;
   logic       cwin_ff, cwin_in;

   logic eq_e, eq_c, ehit, chit, ewin_new, cwin_new, wr;

   always_comb begin
      eq_e     = (qchar_ff == char_byte);
      eq_c     = (lower_ascii(qchar_ff) == char_lower);
      ehit     = etok_ff & used_ff & eq_e;
      chit     = ctok_ff & used_ff & eq_c;
      ewin_new = prev.ewin & eq_e & used_ff;
      cwin_new = prev.cwin & eq_c & used_ff;
      // first free position takes the query character
      wr       = ctl.qwr & (ctl.new_query ? head : (~used_ff & prev.used));
   end

   always_comb begin
      used_in = used_ff;
      if (ctl.qwr) begin
         used_in = ctl.new_query ? head : (used_ff | wr);
      end
      etok_in = etok_ff;
      ctok_in = ctok_ff;
      ewin_in = ewin_ff;
      cwin_in = cwin_ff;
      if (ctl.clear) begin
         etok_in = head;
         ctok_in = head;
         ewin_in = 1'b0;
         cwin_in = 1'b0;
      end else if (ctl.step) begin
         etok_in = (etok_ff & ~ehit) | prev.ehit;
         ctok_in = (ctok_ff & ~chit) | prev.chit;
         ewin_in = ewin_new;
         cwin_in = cwin_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= 1'b0;
         etok_ff <= head;
         ctok_ff <= head;
         ewin_ff <= 1'b0;
         cwin_ff <= 1'b0;
      end else begin
         used_ff <= used_in;
         etok_ff <= etok_in;
         ctok_ff <= ctok_in;
         ewin_ff <= ewin_in;
         cwin_ff <= cwin_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr) begin
         qchar_ff <= char_byte;
      end
   end

   always_comb begin
      link.used  = used_ff;
      link.ehit  = ehit;
      link.chit  = chit;
      link.ewin  = ewin_ff;
      link.cwin  = cwin_ff;
      stat.eact  = etok_ff & used_ff;
      stat.ehit  = ehit;
      stat.cact  = ctok_ff & used_ff;
      stat.chit  = chit;
      stat.econt = ewin_new & ~next_used;
      stat.ccont = cwin_new & ~next_used;
   end

endmodule

FILE: hdl/fpms_score.sv
// final score of a finished path: length bonus by reciprocal multiply, sum, saturation
module fpms_score import fpms_pkg::*; (
   input  fin_type fin,
   output rsp_type rsp
);

   localparam int E_SHIFT = PATH_W + 4;
   localparam int C_SHIFT = PATH_W + 5;
   localparam int E_RECIP = (1 << E_SHIFT) / E_LEN_DIV + 1;
   localparam int C_RECIP = (1 << C_SHIFT) / C_LEN_DIV + 1;
   localparam int PROD_W  = PATH_W + C_SHIFT;
   localparam int SUM_W   = ((PATH_W > PTS_W + 2) ? PATH_W : PTS_W + 2) + 2;

   logic [PROD_W-1:0] e_prod, c_prod;
   logic [PATH_W-1:0] e_quot, c_quot;
   logic [SUM_W-1:0]  e_sum, c_sum, sum;

   always_comb begin
      e_prod = PROD_W'(fin.plen) * PROD_W'(E_RECIP);
      c_prod = PROD_W'(fin.plen) * PROD_W'(C_RECIP);
      e_quot = PATH_W'(e_prod >> E_SHIFT);
      c_quot = PATH_W'(c_prod >> C_SHIFT);
      e_sum  = SUM_W'(fin.pts) + SUM_W'(e_quot)
             + (fin.contained ? SUM_W'(E_CONT_MULT) * SUM_W'(fin.qlen) : '0);
      c_sum  = SUM_W'(fin.pts) + SUM_W'(c_quot)
             + (fin.contained ? SUM_W'(C_CONT_MULT) * SUM_W'(fin.qlen) : '0);
      sum    = fin.exact_ok ? e_sum : c_sum;

      if (!(fin.exact_ok | fin.caseless_ok)) begin
         rsp.score = '0;
      end else if (sum > SUM_W'(SCORE_MAX)) begin
         rsp.score = SCORE_W'(SCORE_MAX);
      end else begin
         rsp.score = sum[SCORE_W-1:0];
      end
      rsp.case_exact = fin.exact_ok;
      rsp.truncated  = fin.truncated;
   end

endmodule

FILE: hdl/fuzzy_path_match_score.sv
// top level of the fuzzy path match scorer: cell row, path state, score stage, output register
//
//   channel  | ports                      | direction | moves
//   request  | req_valid/req_ready/req_item | in      | one query or path character per item
//   response | rsp_valid/rsp_ready/rsp_item | out     | one score item per finished path
//
// one item per cycle while req_ready is high; every cell of the row compares the character in the same cycle
// a path item with last set gives its result through the snapshot stage, then the
// score stage into the output register
// reset is synchronous and clears the query length, path state and the valid flags of both stages
// a waiting result holds the output register; one more finished path may wait in the
// snapshot stage, and only when both are full does req_ready drop
module fuzzy_path_match_score import fpms_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_item,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_item
);

   // handshake and stage control
   logic fin_valid_ff, fin_valid_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_adv;
   fin_type fin_ff, fin_in;
   rsp_type rsp_ff, score_out;

   // query state
   logic [QLEN_W-1:0] qlen_ff, qlen_in;
   logic              closed_ff, closed_in;
   logic              qtrunc_ff, qtrunc_in;

   // per path state
   logic [QLEN_W-1:0] eidx_ff, eidx_in, eidx_upd;
   logic [QLEN_W-1:0] cidx_ff, cidx_in, cidx_upd;
   logic              eadj_ff, eadj_in, eadj_upd;
   logic              cadj_ff, cadj_in, cadj_upd;
   logic [PTS_W-1:0]  epts_ff, epts_in, epts_upd;
   logic [PTS_W-1:0]  cpts_ff, cpts_in, cpts_upd;
   logic              econt_ff, econt_in, econt_upd;
   logic              ccont_ff, ccont_in, ccont_upd;
   logic              palnum_ff, palnum_in, palnum_upd;
   logic [PATH_W-1:0] plen_ff, plen_in, plen_upd;
   logic              ovf_ff, ovf_in, ovf_upd;

   // item decode
   logic acc, is_path, take, pend, alnum, boundary;
   logic [7:0] char_lower;
   cell_ctl_type ctl;

   // cell row wiring
   link_type      link_v [MAX_QUERY+1];
   cell_stat_type stat_v [MAX_QUERY];
   logic [MAX_QUERY:0]   used_v;
   logic [MAX_QUERY-1:0] eact_v, ehit_v, cact_v, chit_v, econt_v, ccont_v;
   logic eact, ehit, cact, chit;
   logic exact_ok, caseless_ok;

   // ---- handshake ----
   always_comb begin
      rsp_adv      = fin_valid_ff & (~rsp_valid_ff | rsp_ready);
      req_ready    = ~fin_valid_ff | rsp_adv;
      acc          = req_valid & req_ready;
      is_path      = (req_item.command == CMD_PATH);
      take         = acc & is_path & (plen_ff < PATH_W'(MAX_PATH_LEN));
      pend         = acc & is_path & req_item.last;
      fin_valid_in = pend | (fin_valid_ff & ~rsp_adv);
      rsp_valid_in = rsp_adv | (rsp_valid_ff & ~rsp_ready);
   end

   // ---- broadcast controls ----
   always_comb begin
      ctl.qwr       = acc & (req_item.command == CMD_QUERY);
      ctl.new_query = ctl.qwr & closed_ff;
      ctl.step      = take;
      // a new query abandons the path in progress; a finished path starts over
      ctl.clear     = ctl.new_query | pend;
      char_lower    = lower_ascii(req_item.char_byte);
      alnum         = is_alnum(req_item.char_byte);
      boundary      = (plen_ff == '0) | (alnum != palnum_ff);
   end

   // ---- cell row ----
   assign link_v[0] = '{used: 1'b1, ehit: 1'b0, chit: 1'b0, ewin: 1'b1, cwin: 1'b1};
   assign used_v[MAX_QUERY] = 1'b0;

   for (genvar i = 0; i < MAX_QUERY; i++) begin : g_cell
      localparam bit IS_HEAD = (i == 0);

      fpms_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .char_byte  (req_item.char_byte),
         .char_lower (char_lower),
         .head       (IS_HEAD),
         .prev       (link_v[i]),
         .next_used  (used_v[i+1]),
         .link       (link_v[i+1]),
         .stat       (stat_v[i])
      );

      assign used_v[i]  = link_v[i+1].used;
      assign eact_v[i]  = stat_v[i].eact;
      assign ehit_v[i]  = stat_v[i].ehit;
      assign cact_v[i]  = stat_v[i].cact;
      assign chit_v[i]  = stat_v[i].chit;
      assign econt_v[i] = stat_v[i].econt;
      assign ccont_v[i] = stat_v[i].ccont;
   end

   always_comb begin
      eact = |eact_v;
      ehit = |ehit_v;
      cact = |cact_v;
      chit = |chit_v;
   end

   // ---- path state after this character ----
   always_comb begin
      eidx_upd   = eidx_ff;
      cidx_upd   = cidx_ff;
      eadj_upd   = eadj_ff;
      cadj_upd   = cadj_ff;
      epts_upd   = epts_ff;
      cpts_upd   = cpts_ff;
      econt_upd  = econt_ff;
      ccont_upd  = ccont_ff;
      palnum_upd = palnum_ff;
      plen_upd   = plen_ff;
      ovf_upd    = ovf_ff | (acc & is_path & ~take);
      if (take) begin
         eidx_upd = eidx_ff + QLEN_W'(ehit);
         cidx_upd = cidx_ff + QLEN_W'(chit);
         // adjacency only moves while that match still has query left
         if (eact) begin
            eadj_upd = ehit;
         end
         if (cact) begin
            cadj_upd = chit;
         end
         if (ehit) begin
            epts_upd = epts_ff + PTS_W'(E_BASE_PTS)
                     + (eadj_ff  ? PTS_W'(E_ADJ_PTS) : '0)
                     + (boundary ? PTS_W'(E_BND_PTS) : '0);
         end
         if (chit) begin
            cpts_upd = cpts_ff + PTS_W'(C_BASE_PTS)
                     + (cadj_ff  ? PTS_W'(C_ADJ_PTS) : '0)
                     + (boundary ? PTS_W'(C_BND_PTS) : '0);
         end
         econt_upd  = econt_ff | (|econt_v);
         ccont_upd  = ccont_ff | (|ccont_v);
         palnum_upd = alnum;
         plen_upd   = plen_ff + PATH_W'(1);
      end
   end

   // ---- next register values ----
   always_comb begin
      if (ctl.clear) begin
         eidx_in   = '0;
         cidx_in   = '0;
         eadj_in   = 1'b1;
         cadj_in   = 1'b1;
         epts_in   = '0;
         cpts_in   = '0;
         econt_in  = 1'b0;
         ccont_in  = 1'b0;
         palnum_in = 1'b0;
         plen_in   = '0;
         ovf_in    = 1'b0;
      end else begin
         eidx_in   = eidx_upd;
         cidx_in   = cidx_upd;
         eadj_in   = eadj_upd;
         cadj_in   = cadj_upd;
         epts_in   = epts_upd;
         cpts_in   = cpts_upd;
         econt_in  = econt_upd;
         ccont_in  = ccont_upd;
         palnum_in = palnum_upd;
         plen_in   = plen_upd;
         ovf_in    = ovf_upd;
      end

      qlen_in   = qlen_ff;
      qtrunc_in = qtrunc_ff;
      closed_in = closed_ff;
      if (ctl.new_query) begin
         qlen_in   = QLEN_W'(1);
         qtrunc_in = 1'b0;
      end else if (ctl.qwr) begin
         if (qlen_ff < QLEN_W'(MAX_QUERY)) begin
            qlen_in = qlen_ff + QLEN_W'(1);
         end else begin
            qtrunc_in = 1'b1;
         end
      end
      if (ctl.qwr) begin
         closed_in = req_item.last;
      end else if (acc & is_path) begin
         // a path character closes a query still open
         closed_in = 1'b1;
      end
   end

   // ---- snapshot of a finished path ----
   always_comb begin
      exact_ok           = (qlen_ff != '0) & (eidx_upd == qlen_ff);
      caseless_ok        = (qlen_ff != '0) & (cidx_upd == qlen_ff);
      fin_in.exact_ok    = exact_ok;
      fin_in.caseless_ok = caseless_ok;
      fin_in.contained   = exact_ok ? econt_upd : ccont_upd;
      fin_in.pts         = exact_ok ? epts_upd : cpts_upd;
      fin_in.qlen        = qlen_ff;
      fin_in.plen        = plen_upd;
      fin_in.truncated   = ovf_upd | qtrunc_ff;
   end

   fpms_score u_score (
      .fin (fin_ff),
      .rsp (score_out)
   );

   // ---- registers ----
   always_ff @(posedge clock) begin
      if (reset) begin
         fin_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         qlen_ff      <= '0;
         closed_ff    <= 1'b1;
         qtrunc_ff    <= 1'b0;
         eidx_ff      <= '0;
         cidx_ff      <= '0;
         eadj_ff      <= 1'b1;
         cadj_ff      <= 1'b1;
         epts_ff      <= '0;
         cpts_ff      <= '0;
         econt_ff     <= 1'b0;
         ccont_ff     <= 1'b0;
         palnum_ff    <= 1'b0;
         plen_ff      <= '0;
         ovf_ff       <= 1'b0;
      end else begin
         fin_valid_ff <= fin_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         qlen_ff      <= qlen_in;
         closed_ff    <= closed_in;
         qtrunc_ff    <= qtrunc_in;
         eidx_ff      <= eidx_in;
         cidx_ff      <= cidx_in;
         eadj_ff      <= eadj_in;
         cadj_ff      <= cadj_in;
         epts_ff      <= epts_in;
         cpts_ff      <= cpts_in;
         econt_ff     <= econt_in;
         ccont_ff     <= ccont_in;
         palnum_ff    <= palnum_in;
         plen_ff      <= plen_in;
         ovf_ff       <= ovf_in;
      end
   end

   // payload stages, no reset
   always_ff @(posedge clock) begin
      if (pend) begin
         fin_ff <= fin_in;
      end
      if (rsp_adv) begin
         rsp_ff <= score_out;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   // ---- checks ----
   a_index_bound: assert property (@(posedge clock) disable iff (reset)
      (eidx_ff <= qlen_ff) && (cidx_ff <= qlen_ff))
      else $error("match index ran past the query length");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (fin_valid_ff && rsp_valid_ff && !rsp_ready))
      else $error("request stalled while a stage was free");

   a_path_cleared: assert property (@(posedge clock) disable iff (reset)
      pend |=> (eidx_ff == '0) && (cidx_ff == '0) && (plen_ff == '0))
      else $error("path state not cleared after a finished path");

   a_exact_scores: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.case_exact) |-> (rsp_item.score != '0))
      else $error("exact match finished with a zero score");

endmodule

FILE: tb/sv/fpms_score_checker.sv
`timescale 1ns / 100ps
// checker that watches both channels, scores each finished path and compares the score items
module fpms_score_checker import fpms_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  req_type     req_item,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  rsp_type     rsp_item,
   output int unsigned mismatch_count,
   output int unsigned scores_pending
);

   // query held by the predictor
   logic [7:0]  query_text [MAX_QUERY];
   int          query_len;
   logic        query_closed;
   logic        query_cut;

   // per path state, one set for the exact match and one for the caseless match
   int          exact_pos, fold_pos;
   logic        exact_run, fold_run;
   int          exact_pts, fold_pts;
   logic [31:0] exact_win, fold_win;
   logic        exact_whole, fold_whole;
   logic        prev_word;
   int          path_len;
   logic        path_cut;

   rsp_type     score_queue [$];
   int unsigned errors;

   function automatic logic word_char(input logic [7:0] c);
      return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
             (c >= 8'h61 && c <= 8'h7A);
   endfunction

   function automatic logic [7:0] fold_char(input logic [7:0] c);
      return (c >= 8'h41 && c <= 8'h5A) ? (c | 8'h20) : c;
   endfunction

   function automatic void clear_path();
      exact_pos   = 0;
      fold_pos    = 0;
      exact_run   = 1'b1;
      fold_run    = 1'b1;
      exact_pts   = 0;
      fold_pts    = 0;
      exact_win   = '0;
      fold_win    = '0;
      exact_whole = 1'b0;
      fold_whole  = 1'b0;
      prev_word   = 1'b0;
      path_len    = 0;
      path_cut    = 1'b0;
   endfunction

   task automatic score_item(input req_type it);
      logic        is_word, boundary;
      logic [7:0]  lc;
      logic [31:0] exact_mask, fold_mask;
      logic        exact_done;
      int          total;
      rsp_type     want;
      if (it.command == CMD_QUERY) begin
         if (query_closed) begin
            query_len    = 0;
            query_cut    = 1'b0;
            query_closed = 1'b0;
            clear_path();
         end
         if (query_len < MAX_QUERY) begin
            query_text[query_len] = it.char_byte;
            query_len++;
         end else begin
            query_cut = 1'b1;
         end
         if (it.last)
            query_closed = 1'b1;
         return;
      end

      query_closed = 1'b1;
      if (path_len < MAX_PATH_LEN) begin
         is_word  = word_char(it.char_byte);
         boundary = (path_len == 0) || (is_word != prev_word);
         lc       = fold_char(it.char_byte);
         if (exact_pos < query_len) begin
            if (query_text[exact_pos] == it.char_byte) begin
               exact_pts += E_BASE_PTS + (exact_run ? E_ADJ_PTS : 0) + (boundary ? E_BND_PTS : 0);
               exact_pos++;
               exact_run = 1'b1;
            end else begin
               exact_run = 1'b0;
            end
         end
         if (fold_pos < query_len) begin
            if (fold_char(query_text[fold_pos]) == lc) begin
               fold_pts += C_BASE_PTS + (fold_run ? C_ADJ_PTS : 0) + (boundary ? C_BND_PTS : 0);
               fold_pos++;
               fold_run = 1'b1;
            end else begin
               fold_run = 1'b0;
            end
         end
         exact_mask = '0;
         fold_mask  = '0;
         for (int i = 0; i < query_len; i++) begin
            exact_mask[i] = (query_text[i] == it.char_byte);
            fold_mask[i]  = (fold_char(query_text[i]) == lc);
         end
         exact_win = ((exact_win << 1) | 32'd1) & exact_mask;
         fold_win  = ((fold_win << 1) | 32'd1) & fold_mask;
         if (query_len > 0) begin
            if (exact_win[query_len-1])
               exact_whole = 1'b1;
            if (fold_win[query_len-1])
               fold_whole = 1'b1;
         end
         prev_word = is_word;
         path_len++;
      end else begin
         path_cut = 1'b1;
      end
      if (!it.last)
         return;

      total      = 0;
      exact_done = (query_len > 0) && (exact_pos == query_len);
      if (exact_done)
         total = exact_pts + (exact_whole ? E_CONT_MULT * query_len : 0) + path_len / E_LEN_DIV;
      else if (query_len > 0 && fold_pos == query_len)
         total = fold_pts + (fold_whole ? C_CONT_MULT * query_len : 0) + path_len / C_LEN_DIV;
      if (total > SCORE_MAX)
         total = SCORE_MAX;
      want.score      = SCORE_W'(total);
      want.case_exact = exact_done;
      want.truncated  = path_cut || query_cut;
      score_queue = {score_queue, want};
      clear_path();
   endtask

   always @(posedge clock) begin : watch
      rsp_type want;
      if (reset) begin
         query_len    = 0;
         query_closed = 1'b1;
         query_cut    = 1'b0;
         clear_path();
         score_queue.delete();
      end else begin
         if (req_valid && req_ready)
            score_item(req_item);
         if (rsp_valid && rsp_ready) begin
            if (score_queue.size() == 0) begin
               errors++;
               $display("%0t: score item with none expected, actual %0d/%0b/%0b",
                        $time, rsp_item.score, rsp_item.case_exact, rsp_item.truncated);
            end else begin
               want = score_queue.pop_front();
               if (rsp_item.score !== want.score) begin
                  errors++;
                  $display("%0t: score expected %0d actual %0d",
                           $time, want.score, rsp_item.score);
               end
               if (rsp_item.case_exact !== want.case_exact) begin
                  errors++;
                  $display("%0t: case_exact expected %0b actual %0b",
                           $time, want.case_exact, rsp_item.case_exact);
               end
               if (rsp_item.truncated !== want.truncated) begin
                  errors++;
                  $display("%0t: truncated expected %0b actual %0b",
                           $time, want.truncated, rsp_item.truncated);
               end
            end
         end
      end
      mismatch_count <= errors;
      scores_pending <= score_queue.size();
   end

endmodule

FILE: tb/sv/tb_fuzzy_path_match_score.sv
`timescale 1ns / 100ps
// top of the fuzzy path match scorer testbench: clock, reset, traffic and verdict
module tb_fuzzy_path_match_score import fpms_pkg::*; ();

   typedef logic [7:0] char_list [$];

   // cycles with no item moving on either channel before the run is called hung
   localparam int IDLE_LIMIT   = 3000;
   // receiver hold-off long enough to back the block up into its input
   localparam int SQUEEZE_SPAN = 400;
   // random part length, in ordinary items
   localparam int RANDOM_ITEMS = 1000;

   // small alphabet so that queries and paths actually hit each other
   localparam logic [7:0] ALPHABET [12] = '{"a", "A", "b", "B", "c", "Z",
                                            "0", "9", "/", ".", "_", "-"};

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_item = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_item;
   logic        squeeze_request = 1'b0;

   int unsigned mismatch_count;
   int unsigned scores_pending;
   int unsigned idle_cycles = 0;

   // sender bookkeeping
   int          items_sent = 0;
   int          bulk_items = 0;
   int          burst_left = 0;
   logic [7:0]  cur_query [$];

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   fuzzy_path_match_score dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

   fpms_score_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_item       (req_item),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_item       (rsp_item),
      .mismatch_count (mismatch_count),
      .scores_pending (scores_pending)
   );

   // mostly the small alphabet, now and then any byte at all
   function automatic logic [7:0] pick_char();
      if ($urandom_range(0, 6) == 0)
         return 8'($urandom_range(0, 255));
      return ALPHABET[$urandom_range(0, 11)];
   endfunction

   // swap ascii letter case, leave everything else alone
   function automatic logic [7:0] flip_case(input logic [7:0] c);
      if ((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A))
         return c ^ 8'h20;
      return c;
   endfunction

   // one item on the request channel; bursts of random length with random gaps between
   task automatic push_item(input logic cmd, input logic [7:0] ch, input logic last_flag);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 48);
         if ($urandom_range(0, 3) != 0) begin
            gap = $urandom_range(1, 9);
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_item  <= '{command: cmd, char_byte: ch, last: last_flag};
      req_valid <= 1'b1;
      do
         @(posedge clock);
      while (!req_ready);
      items_sent++;
   endtask

   // a fresh query; left open means no last flag, so the next path has to close it
   task automatic load_query(input int len, input bit leave_open);
      logic [7:0] ch;
      cur_query.delete();
      for (int i = 0; i < len; i++) begin
         ch = pick_char();
         cur_query = {cur_query, ch};
         push_item(CMD_QUERY, ch, !leave_open && i == len - 1);
      end
   endtask

   task automatic send_path(input char_list chars, input bit finish);
      for (int i = 0; i < chars.size(); i++)
         push_item(CMD_PATH, chars[i], finish && i == chars.size() - 1);
   endtask

   // path that carries the stored part of the query as a subsequence, with noise and
   // case flips around it; tight means no noise between query characters
   task automatic make_crafted(input bit tight, output char_list chars);
      int n;
      chars.delete();
      repeat ($urandom_range(0, 2)) chars = {chars, pick_char()};
      n = (cur_query.size() > MAX_QUERY) ? MAX_QUERY : cur_query.size();
      for (int i = 0; i < n; i++) begin
         if (!tight)
            repeat ($urandom_range(0, 2)) chars = {chars, pick_char()};
         chars = {chars, (($urandom_range(0, 4) == 0) ? flip_case(cur_query[i])
                                                       : cur_query[i])};
      end
      repeat ($urandom_range(0, 2)) chars = {chars, pick_char()};
      if (chars.size() == 0)
         chars = {chars, pick_char()};
   endtask

   task automatic make_noise(input int len, output char_list chars);
      chars.delete();
      repeat (len) chars = {chars, pick_char()};
   endtask

   // a path past the length bound, query up front so it still scores
   task automatic send_bulk_path(input int len);
      char_list chars;
      make_crafted(1'b1, chars);
      while (chars.size() < len)
         chars = {chars, pick_char()};
      bulk_items += chars.size();
      send_path(chars, 1'b1);
   endtask

   // receiver: stall pattern changes every so often, plus one long hold-off on request
   initial begin : receiver
      int  mode, phase_left, hold_left;
      bit  squeeze_done;
      mode = 0;
      phase_left = 0;
      hold_left = 0;
      squeeze_done = 0;
      forever begin
         @(posedge clock);
         if (squeeze_request && !squeeze_done) begin
            squeeze_done = 1;
            hold_left = SQUEEZE_SPAN;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            if (phase_left == 0) begin
               mode = $urandom_range(0, 3);
               phase_left = $urandom_range(16, 200);
            end
            phase_left--;
            case (mode)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= 1'($urandom_range(0, 1));
               2: rsp_ready <= ($urandom_range(0, 9) == 0);
               default: rsp_ready <= ($urandom_range(0, 9) != 0);
            endcase
         end
      end
   end

   // hang detector: nothing moving for too long means a lost item or a stuck handshake
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("fuzzy_path_match_score: mismatch");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : stimulus
      char_list chars;
      int       qlen, kind;
      bit       force_query, open_query, bulk_done;
      force_query = 0;
      bulk_done = 0;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // ---- directed part ----
      // empty query right after reset: every path scores zero
      push_item(CMD_PATH, "a", 1'b0);
      push_item(CMD_PATH, 8'hFF, 1'b1);
      // query "aB", then an exact hit across a word boundary
      push_item(CMD_QUERY, "a", 1'b0);
      push_item(CMD_QUERY, "B", 1'b1);
      push_item(CMD_PATH, "x", 1'b0);
      push_item(CMD_PATH, "a", 1'b0);
      push_item(CMD_PATH, "/", 1'b0);
      push_item(CMD_PATH, "B", 1'b1);
      // only the caseless match completes, contiguous
      push_item(CMD_PATH, "A", 1'b0);
      push_item(CMD_PATH, "B", 1'b1);
      // non-ascii bytes and a zero byte: never alphanumeric, never lowered
      push_item(CMD_PATH, 8'h00, 1'b0);
      push_item(CMD_PATH, 8'hC1, 1'b1);
      // path in progress abandoned by a new query
      push_item(CMD_PATH, "a", 1'b0);
      push_item(CMD_QUERY, "q", 1'b1);
      // open query closed by a path character, caseless hit
      push_item(CMD_QUERY, "Z", 1'b0);
      push_item(CMD_PATH, "z", 1'b1);
      // exact, contained, first character on the path start boundary
      push_item(CMD_PATH, "Z", 1'b1);

      // ---- random part ----
      // receiver holds off right away while traffic keeps coming
      squeeze_request <= 1'b1;
      while (items_sent - bulk_items < RANDOM_ITEMS) begin
         // one path past the length bound, done once midway
         if (!bulk_done && items_sent > RANDOM_ITEMS / 2) begin
            bulk_done = 1;
            load_query($urandom_range(1, 4), 1'b0);
            send_bulk_path(MAX_PATH_LEN + $urandom_range(1, 3));
         end
         if (force_query || $urandom_range(0, 3) == 0) begin
            // mostly short queries, sometimes past the query bound
            qlen = ($urandom_range(0, 11) == 0) ? $urandom_range(MAX_QUERY + 1, MAX_QUERY + 4)
                                                : $urandom_range(1, 6);
            open_query = ($urandom_range(0, 6) == 0);
            load_query(qlen, open_query);
            force_query = 0;
         end
         repeat ($urandom_range(1, 4)) begin
            kind = $urandom_range(0, 19);
            if (kind < 11) begin
               make_crafted(kind < 4, chars);
               send_path(chars, 1'b1);
            end else if (kind < 17) begin
               make_noise($urandom_range(1, 16), chars);
               send_path(chars, 1'b1);
            end else begin
               // broken path: no last, next query throws it away
               make_noise($urandom_range(1, 8), chars);
               send_path(chars, 1'b0);
               force_query = 1;
               break;
            end
         end
      end
      req_valid <= 1'b0;

      // let the checker see the final item, then drain and settle
      @(posedge clock);
      while (scores_pending != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);

      if (mismatch_count == 0 && scores_pending == 0)
         $display("fuzzy_path_match_score: match");
      else
         $display("fuzzy_path_match_score: mismatch");
      $finish;
   end

endmodule

FILE: fuzzy_path_match_score.f
hdl/fpms_pkg.sv
hdl/fpms_cell.sv
hdl/fpms_score.sv
hdl/fuzzy_path_match_score.sv
tb/sv/fpms_score_checker.sv
tb/sv/tb_fuzzy_path_match_score.sv
